// ===== rtl/spd_pkg.sv =====
`timescale 1ns / 1ps
package spd_pkg;

  // Frame layout and limits
  localparam int MAX_PACKET  = 128;
  localparam int MAX_RESULTS = 20;
  localparam int HDR_BYTES   = 5;
  localparam int REC_BYTES   = 6;
  localparam int MIN_LENGTH  = 6;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = $clog2(MAX_PACKET + 1);
  localparam int RCNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int RIDX_W   = $clog2(MAX_RESULTS);
  localparam int RBYTE_W  = $clog2(REC_BYTES);
  localparam int REC_W    = REC_BYTES * BYTE_W;
  localparam int ASM_W    = (REC_BYTES - 1) * BYTE_W;
  localparam int KIND_W   = 2;
  localparam int ID_W     = 16;
  localparam int VALUE_W  = 32;

  localparam logic [BYTE_W-1:0] SYNC_BYTE    = 8'hFF;
  localparam logic [BYTE_W-1:0] MSG_DATA     = 8'd1;
  localparam logic [BYTE_W-1:0] MSG_SEND_ALL = 8'd2;

  // Event kinds on the result channel
  localparam logic [KIND_W-1:0] EVT_RECORD   = 2'd0;
  localparam logic [KIND_W-1:0] EVT_SEND_ALL = 2'd1;
  localparam logic [KIND_W-1:0] EVT_RESEND   = 2'd2;

  typedef enum logic [3:0] {
    ST_SYNC0,
    ST_SYNC1,
    ST_MSG,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_BODY,
    ST_REC_RD,
    ST_OUT
  } spd_state_t;

  typedef struct packed {
    logic              start;
    logic              add_sum;
    logic              ld_msg;
    logic              ld_len_lo;
    logic              ld_len_hi;
    logic              body;
    logic              ld_evt;
    logic [KIND_W-1:0] evt_kind;
    logic              load_rec;
    logic              next_rec;
  } spd_cmd_t;

  typedef struct packed {
    logic is_sync;
    logic len_ok;
    logic at_ck;
    logic sum_ok;
    logic msg_data;
    logic msg_all;
    logic has_rec;
    logic out_last;
  } spd_stat_t;

endpackage

// ===== rtl/spd_in_if.sv =====
`timescale 1ns / 1ps
interface spd_in_if;
  import spd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/spd_out_if.sv =====
`timescale 1ns / 1ps
interface spd_out_if;
  import spd_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  event_kind;
  logic [ID_W-1:0]    record_id;
  logic [VALUE_W-1:0] record_value;
  logic               last;

  modport source (output valid, output event_kind, output record_id,
                  output record_value, output last, input ready);
  modport sink (input valid, input event_kind, input record_id,
                input record_value, input last, output ready);
endinterface

// ===== rtl/spd_dp.sv =====
`timescale 1ns / 1ps
module spd_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [spd_pkg::BYTE_W-1:0] in_byte,
  input  spd_pkg::spd_cmd_t          cmd,
  output spd_pkg::spd_stat_t         stat,
  output logic [spd_pkg::KIND_W-1:0] out_kind,
  output logic [spd_pkg::ID_W-1:0]   out_id,
  output logic [spd_pkg::VALUE_W-1:0] out_value,
  output logic                       out_last
);
  import spd_pkg::*;

  logic [BYTE_W-1:0]  sum_r;
  logic [BYTE_W-1:0]  msg_r;
  logic [BYTE_W-1:0]  len_lo_r;
  logic [LEN_W-1:0]   len_r;
  logic [LEN_W-1:0]   pos_r;
  logic [RBYTE_W-1:0] rec_byte_r;
  logic [RCNT_W-1:0]  rec_cnt_r;
  logic [RIDX_W-1:0]  rd_idx_r;
  logic [ASM_W-1:0]   asm_r;
  logic [KIND_W-1:0]  kind_r;
  logic [ID_W-1:0]    id_r;
  logic [VALUE_W-1:0] value_r;
  logic               last_r;
  logic [REC_W-1:0]   rec_mem [MAX_RESULTS];

  logic [2*BYTE_W-1:0] len_full;
  logic                rec_done;
  logic                rec_room;

  assign len_full = {in_byte, len_lo_r};
  assign rec_done = cmd.body && (rec_byte_r == RBYTE_W'(REC_BYTES - 1));
  assign rec_room = rec_cnt_r < RCNT_W'(MAX_RESULTS);

  // Status toward the controller
  always_comb begin
    stat.is_sync  = in_byte == SYNC_BYTE;
    stat.len_ok   = (len_full <= (2*BYTE_W)'(MAX_PACKET)) &&
                    (len_full >= (2*BYTE_W)'(MIN_LENGTH));
    stat.at_ck    = (pos_r + LEN_W'(1)) == len_r;
    stat.sum_ok   = in_byte == sum_r;
    stat.msg_data = msg_r == MSG_DATA;
    stat.msg_all  = msg_r == MSG_SEND_ALL;
    stat.has_rec  = rec_cnt_r != '0;
    stat.out_last = last_r;
  end

  // Frame counters and record bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_byte_r <= '0;
      rec_cnt_r  <= '0;
      rd_idx_r   <= '0;
    end else if (cmd.start) begin
      rec_byte_r <= '0;
      rec_cnt_r  <= '0;
      rd_idx_r   <= '0;
    end else begin
      if (cmd.body) begin
        if (rec_done) begin
          rec_byte_r <= '0;
          if (rec_room) begin
            rec_cnt_r <= rec_cnt_r + RCNT_W'(1);
          end
        end else begin
          rec_byte_r <= rec_byte_r + RBYTE_W'(1);
        end
      end
      if (cmd.next_rec) begin
        rd_idx_r <= rd_idx_r + RIDX_W'(1);
      end
    end
  end

  // Header fields, checksum and byte position
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sum_r <= SYNC_BYTE;
    end else if (cmd.add_sum) begin
      sum_r <= sum_r + in_byte;
    end
    if (cmd.ld_msg) begin
      msg_r <= in_byte;
    end
    if (cmd.ld_len_lo) begin
      len_lo_r <= in_byte;
    end
    if (cmd.ld_len_hi) begin
      len_r <= len_full[LEN_W-1:0];
      pos_r <= LEN_W'(HDR_BYTES);
    end else if (cmd.body) begin
      pos_r <= pos_r + LEN_W'(1);
    end
    if (cmd.body) begin
      asm_r <= {in_byte, asm_r[ASM_W-1:BYTE_W]};
    end
  end

  // Store each whole record, little-endian byte order
  always_ff @(posedge clk) begin
    if (rec_done && rec_room) begin
      rec_mem[rec_cnt_r[RIDX_W-1:0]] <= {in_byte, asm_r};
    end
  end

  // Result register: event or record read from the store
  always_ff @(posedge clk) begin
    if (cmd.ld_evt) begin
      kind_r  <= cmd.evt_kind;
      id_r    <= '0;
      value_r <= '0;
      last_r  <= 1'b1;
    end else if (cmd.load_rec) begin
      kind_r            <= EVT_RECORD;
      {value_r, id_r}   <= rec_mem[rd_idx_r];
      last_r            <= (RCNT_W'(rd_idx_r) + RCNT_W'(1)) == rec_cnt_r;
    end
  end

  assign out_kind  = kind_r;
  assign out_id    = id_r;
  assign out_value = value_r;
  assign out_last  = last_r;

endmodule

// ===== rtl/spd_ctrl.sv =====
`timescale 1ns / 1ps
module spd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  spd_pkg::spd_stat_t stat,
  output spd_pkg::spd_cmd_t  cmd
);
  import spd_pkg::*;

  spd_state_t state_r;
  spd_state_t state_nxt;
  logic       in_acc;

  assign in_acc = in_valid && in_ready;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SYNC0;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_SYNC0: begin
        in_ready = 1'b1;
        if (in_acc && stat.is_sync) begin
          cmd.start = 1'b1;
          state_nxt = ST_SYNC1;
        end
      end
      ST_SYNC1: begin
        in_ready = 1'b1;
        if (in_acc) begin
          if (stat.is_sync) begin
            cmd.add_sum = 1'b1;
            state_nxt   = ST_MSG;
          end else begin
            state_nxt = ST_SYNC0;
          end
        end
      end
      ST_MSG: begin
        in_ready = 1'b1;
        if (in_acc) begin
          cmd.ld_msg  = 1'b1;
          cmd.add_sum = 1'b1;
          state_nxt   = ST_LEN_LO;
        end
      end
      ST_LEN_LO: begin
        in_ready = 1'b1;
        if (in_acc) begin
          cmd.ld_len_lo = 1'b1;
          cmd.add_sum   = 1'b1;
          state_nxt     = ST_LEN_HI;
        end
      end
      ST_LEN_HI: begin
        in_ready = 1'b1;
        if (in_acc) begin
          if (stat.len_ok) begin
            cmd.ld_len_hi = 1'b1;
            cmd.add_sum   = 1'b1;
            state_nxt     = ST_BODY;
          end else begin
            state_nxt = ST_SYNC0;
          end
        end
      end
      ST_BODY: begin
        in_ready = 1'b1;
        if (in_acc) begin
          if (!stat.at_ck) begin
            cmd.body    = 1'b1;
            cmd.add_sum = 1'b1;
          end else if (!stat.sum_ok) begin
            cmd.ld_evt   = 1'b1;
            cmd.evt_kind = EVT_RESEND;
            state_nxt    = ST_OUT;
          end else if (stat.msg_all) begin
            cmd.ld_evt   = 1'b1;
            cmd.evt_kind = EVT_SEND_ALL;
            state_nxt    = ST_OUT;
          end else if (stat.msg_data && stat.has_rec) begin
            state_nxt = ST_REC_RD;
          end else begin
            state_nxt = ST_SYNC0;
          end
        end
      end
      ST_REC_RD: begin
        cmd.load_rec = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.out_last) begin
            state_nxt = ST_SYNC0;
          end else begin
            cmd.next_rec = 1'b1;
            state_nxt    = ST_REC_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_SYNC0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_bad_sum_resend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BODY && in_acc && stat.at_ck && !stat.sum_ok)
      |=> (state_r == ST_OUT && stat.out_last))
    else $error("checksum mismatch did not raise a resend beat");

  a_read_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REC_RD) |=> (state_r == ST_OUT))
    else $error("record read not followed by output");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && stat.out_last) |=> (state_r == ST_SYNC0))
    else $error("last beat did not return to hunting");
`endif

endmodule

// ===== rtl/serial_packet_deframer_core.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Handshake      Beat contents
// in_ch    in   valid / ready  rx_byte
// out_ch   out  valid / ready  event_kind, record_id, record_value, last
//
// Received bytes are accepted in every parsing state; input is held off while results drain.
// After the checksum byte: a resend or send-all event is presented in the following cycle.
// Each data record is read from the record store, then presented as an output beat.
// Reset is synchronous, active low; the record store needs no clearing pass.
// A stall on out_ch holds the current beat and keeps in_ch ready low.
module serial_packet_deframer_core (
  input  logic clk,
  input  logic rst_n,
  spd_in_if.sink    in_ch,
  spd_out_if.source out_ch
);
  import spd_pkg::*;

  spd_cmd_t  cmd;
  spd_stat_t stat;

  spd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_ch.rx_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_kind  (out_ch.event_kind),
    .out_id    (out_ch.record_id),
    .out_value (out_ch.record_value),
    .out_last  (out_ch.last)
  );

endmodule
